// ----- rtl/core/scpf_pkg.sv -----
// Shared types and constants for the servo command packet framer.
package scpf_pkg;

    localparam int MAX_ENTRIES = 32;

    localparam logic [5:0] COUNT_MAX = 6'(MAX_ENTRIES);

    localparam logic [7:0] HDR_SYNC_A  = 8'hFA;
    localparam logic [7:0] HDR_SYNC_B  = 8'hAF;
    localparam logic [7:0] ADDR_MOVE   = 8'h1E;
    localparam logic [7:0] ADDR_TORQUE = 8'h24;
    localparam logic [7:0] LEN_MOVE    = 8'h04 + 8'h01;
    localparam logic [7:0] LEN_TORQUE  = 8'h01 + 8'h01;

    localparam logic KIND_MOVE   = 1'b0;
    localparam logic KIND_TORQUE = 1'b1;

    // byte slots of one entry, in transmit order
    localparam logic [3:0] SLOT_SYNC_A = 4'd0;
    localparam logic [3:0] SLOT_SYNC_B = 4'd1;
    localparam logic [3:0] SLOT_ZERO_A = 4'd2;
    localparam logic [3:0] SLOT_ZERO_B = 4'd3;
    localparam logic [3:0] SLOT_ADDR   = 4'd4;
    localparam logic [3:0] SLOT_LEN    = 4'd5;
    localparam logic [3:0] SLOT_COUNT  = 4'd6;
    localparam logic [3:0] SLOT_ID     = 4'd7;
    localparam logic [3:0] SLOT_PAY0   = 4'd8;
    localparam logic [3:0] SLOT_PAY1   = 4'd9;
    localparam logic [3:0] SLOT_PAY2   = 4'd10;
    localparam logic [3:0] SLOT_PAY3   = 4'd11;
    localparam logic [3:0] SLOT_CSUM   = 4'd12;

    typedef struct packed {
        logic               req_type;
        logic [7:0]         first_id;
        logic [5:0]         servo_count;
        logic signed [15:0] position;
        logic [15:0]        move_time;
        logic [7:0]         torque_mode;
    } scpf_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
    } scpf_out_t;

    // one classified entry, handed from front to back
    typedef struct packed {
        logic        first;
        logic        last;
        logic        kind;
        logic [5:0]  count;
        logic [7:0]  servo_id;
        logic [15:0] position;
        logic [15:0] move_time;
        logic [7:0]  torque_mode;
    } scpf_job_t;

endpackage

// ----- rtl/core/scpf_front.sv -----
// Front end: accepts entries, tracks packet position, builds job records.
module scpf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  scpf_pkg::scpf_in_t item,
    input  logic              job_full,
    output logic              job_push,
    output scpf_pkg::scpf_job_t job
);
    import scpf_pkg::*;

    logic [5:0] idx_reg, idx_next;
    logic [5:0] count_reg, count_next;
    logic       kind_reg, kind_next;
    logic [7:0] start_reg, start_next;

    logic       first;
    logic [5:0] count_in;
    logic [5:0] count_eff;
    logic       kind_eff;
    logic [7:0] start_eff;
    logic [6:0] idx_inc;
    logic       last;

    assign job_push = push && !job_full;
    assign first    = (idx_reg == 6'd0);

    always_comb
    begin
        priority if (item.servo_count == 6'd0)
            count_in = 6'd1;
        else if (item.servo_count > COUNT_MAX)
            count_in = COUNT_MAX;
        else
            count_in = item.servo_count;
    end

    assign count_eff = first ? count_in : count_reg;
    assign kind_eff  = first ? item.req_type : kind_reg;
    assign start_eff = first ? item.first_id : start_reg;
    assign idx_inc   = {1'b0, idx_reg} + 7'd1;
    assign last      = (idx_inc >= {1'b0, count_eff});

    always_comb
    begin
        job.first       = first;
        job.last        = last;
        job.kind        = kind_eff;
        job.count       = count_eff;
        job.servo_id    = start_eff + {2'b00, idx_reg};
        job.position    = item.position;
        job.move_time   = item.move_time;
        job.torque_mode = item.torque_mode;
    end

    always_comb
    begin
        idx_next   = idx_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        start_next = start_reg;
        if (job_push)
        begin
            idx_next   = last ? 6'd0 : idx_inc[5:0];
            count_next = count_eff;
            kind_next  = kind_eff;
            start_next = start_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 6'd0;
            count_reg <= 6'd0;
            kind_reg  <= 1'b0;
            start_reg <= 8'd0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
            start_reg <= start_next;
        end
    end

endmodule

// ----- rtl/core/scpf_queue.sv -----
// Two-entry job queue between front and back.
module scpf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  scpf_pkg::scpf_job_t wr_job,
    output logic                full,
    input  logic                rd_en,
    output scpf_pkg::scpf_job_t rd_job,
    output logic                valid
);
    import scpf_pkg::*;

    scpf_job_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full   = (cnt_reg == 2'd2);
    assign valid  = (cnt_reg != 2'd0);
    assign rd_job = slot_reg[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/scpf_back.sv -----
// Back end: walks each job's byte slots, keeps the checksum, holds the output byte.
module scpf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  scpf_pkg::scpf_job_t job,
    output logic                job_pop,
    output logic                empty,
    input  logic                pop,
    output scpf_pkg::scpf_out_t result
);
    import scpf_pkg::*;

    logic       active_reg, active_next;
    logic [3:0] slot_reg, slot_next;
    logic [7:0] csum_reg, csum_next;
    scpf_out_t  out_reg, out_next;
    logic       ovalid_reg, ovalid_next;

    logic       advance;
    logic [3:0] cur_slot;
    logic [7:0] byte_val;
    logic       pay_end;
    logic       job_done;

    assign advance  = job_valid && (!ovalid_reg || pop);
    assign cur_slot = active_reg ? slot_reg : (job.first ? SLOT_SYNC_A : SLOT_ID);
    assign pay_end  = (job.kind == KIND_TORQUE) ? (cur_slot == SLOT_PAY0)
                                                : (cur_slot == SLOT_PAY3);
    assign job_done = (cur_slot == SLOT_CSUM) || (pay_end && !job.last);
    assign job_pop  = advance && job_done;
    assign empty    = !ovalid_reg;
    assign result   = out_reg;

    always_comb
    begin
        unique case (cur_slot)
            SLOT_SYNC_A: byte_val = HDR_SYNC_A;
            SLOT_SYNC_B: byte_val = HDR_SYNC_B;
            SLOT_ZERO_A: byte_val = 8'h00;
            SLOT_ZERO_B: byte_val = 8'h00;
            SLOT_ADDR:   byte_val = (job.kind == KIND_TORQUE) ? ADDR_TORQUE : ADDR_MOVE;
            SLOT_LEN:    byte_val = (job.kind == KIND_TORQUE) ? LEN_TORQUE : LEN_MOVE;
            SLOT_COUNT:  byte_val = {2'b00, job.count};
            SLOT_ID:     byte_val = job.servo_id;
            SLOT_PAY0:   byte_val = (job.kind == KIND_TORQUE) ? job.torque_mode
                                                              : job.position[7:0];
            SLOT_PAY1:   byte_val = job.position[15:8];
            SLOT_PAY2:   byte_val = job.move_time[7:0];
            SLOT_PAY3:   byte_val = job.move_time[15:8];
            SLOT_CSUM:   byte_val = csum_reg;
            default:     byte_val = 8'h00;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        slot_next   = slot_reg;
        csum_next   = csum_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        if (advance)
        begin
            out_next.out_byte   = byte_val;
            out_next.packet_end = (cur_slot == SLOT_CSUM);
            ovalid_next         = 1'b1;
            if (job_done)
            begin
                active_next = 1'b0;
            end
            else
            begin
                active_next = 1'b1;
                slot_next   = (pay_end && job.last) ? SLOT_CSUM : cur_slot + 4'd1;
            end
            // checksum covers the first zero-sync byte onward
            priority if (cur_slot == SLOT_CSUM)
                csum_next = 8'h00;
            else if (cur_slot == SLOT_ZERO_A)
                csum_next = byte_val;
            else if (cur_slot > SLOT_ZERO_A)
                csum_next = csum_reg ^ byte_val;
        end
        else if (pop)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            slot_reg   <= SLOT_SYNC_A;
            csum_reg   <= 8'h00;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            slot_reg   <= slot_next;
            csum_reg   <= csum_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_active_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> job_valid)
        else $error("sequencer mid-entry with no job queued");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (slot_reg != SLOT_SYNC_A && slot_reg <= SLOT_CSUM))
        else $error("sequencer slot out of range");

    a_csum_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cur_slot == SLOT_CSUM) |-> (job_pop && job.last))
        else $error("checksum byte without closing the last entry");

    a_end_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cur_slot == SLOT_CSUM) |=> (csum_reg == 8'h00 && !active_reg))
        else $error("checksum not cleared after packet end");

endmodule

// ----- rtl/core/servo_command_packet_framer.sv -----
// Top level of the servo command packet framer.
//
//  channel   direction  handshake             payload
//  entry     in         push / full           item   (scpf_in_t)
//  byte      out        pop / empty           result (scpf_out_t)
//
// One output byte per clock from the back sequencer's output register, while a job is queued and pop keeps up.
// A move entry is 5 bytes, a torque entry 2; the first entry of a
// packet adds 7 header bytes and the last adds 1 checksum byte.
// Entries are taken while the two-entry job queue has room, so the front
// accepts while the back still drains an earlier entry.
// rst_n clears packet position, queue and output valid; no clearing pass.
// A stalled pop holds the output byte and backs up through the queue to full.
module servo_command_packet_framer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  scpf_pkg::scpf_in_t  item,
    output logic                empty,
    input  logic                pop,
    output scpf_pkg::scpf_out_t result
);
    import scpf_pkg::*;

    logic      job_push;
    scpf_job_t front_job;
    scpf_job_t head_job;
    logic      head_valid;
    logic      head_pop;

    scpf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .job_full (full),
        .job_push (job_push),
        .job      (front_job)
    );

    scpf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (front_job),
        .full   (full),
        .rd_en  (head_pop),
        .rd_job (head_job),
        .valid  (head_valid)
    );

    scpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_pop   (head_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ----- tb/sv/servo_command_packet_framer_tb.sv -----
// Testbench for the servo command packet framer: directed and random packets checked byte by byte.
module servo_command_packet_framer_tb;

    import scpf_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       push  = 1'b0;
    logic       full;
    scpf_in_t   item  = '0;
    logic       empty;
    logic       pop   = 1'b0;
    scpf_out_t  result;

    // packet builder state, mirrors the block
    logic [5:0] pkt_entry_idx = '0;
    logic [7:0] pkt_csum      = '0;
    logic [5:0] pkt_count     = '0;
    logic       pkt_kind      = KIND_MOVE;
    logic [7:0] pkt_start_id  = '0;

    scpf_out_t  pending_bytes[$];
    int         fail_count = 0;
    int         entries_sent = 0;

    bit         tx_idle_on = 1'b1;
    bit         rx_idle_on = 1'b1;
    bit         rx_hold_req = 1'b0;
    int         rx_stall = 0;

    servo_command_packet_framer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [5:0] taken_count(input logic [5:0] requested);
        if (requested == 6'd0)
            return 6'd1;
        if (requested > COUNT_MAX)
            return COUNT_MAX;
        return requested;
    endfunction

    function automatic void note_byte(input logic [7:0] b, input logic last);
        scpf_out_t r;
        r.out_byte   = b;
        r.packet_end = last;
        pending_bytes.push_back(r);
    endfunction

    function automatic void note_summed(input logic [7:0] b);
        pkt_csum = pkt_csum ^ b;
        note_byte(b, 1'b0);
    endfunction

    // expected bytes for one accepted entry
    function automatic void frame_entry(input scpf_in_t it);
        if (pkt_entry_idx == 6'd0)
        begin
            pkt_count    = taken_count(it.servo_count);
            pkt_kind     = it.req_type;
            pkt_start_id = it.first_id;
            pkt_csum     = 8'h00;
            note_byte(HDR_SYNC_A, 1'b0);
            note_byte(HDR_SYNC_B, 1'b0);
            note_summed(8'h00);
            note_summed(8'h00);
            note_summed(pkt_kind == KIND_TORQUE ? ADDR_TORQUE : ADDR_MOVE);
            note_summed(pkt_kind == KIND_TORQUE ? LEN_TORQUE : LEN_MOVE);
            note_summed({2'b00, pkt_count});
        end
        note_summed(pkt_start_id + {2'b00, pkt_entry_idx});
        if (pkt_kind == KIND_MOVE)
        begin
            note_summed(it.position[7:0]);
            note_summed(it.position[15:8]);
            note_summed(it.move_time[7:0]);
            note_summed(it.move_time[15:8]);
        end
        else
        begin
            note_summed(it.torque_mode);
        end
        pkt_entry_idx = pkt_entry_idx + 6'd1;
        if (pkt_entry_idx >= pkt_count)
        begin
            note_byte(pkt_csum, 1'b1);
            pkt_entry_idx = 6'd0;
            pkt_csum      = 8'h00;
        end
    endfunction

    function automatic scpf_in_t random_item();
        scpf_in_t it;
        it.req_type    = 1'($urandom);
        it.first_id    = 8'($urandom);
        it.servo_count = 6'($urandom);
        it.position    = 16'($urandom);
        it.move_time   = 16'($urandom);
        it.torque_mode = 8'($urandom);
        return it;
    endfunction

    function automatic scpf_in_t mk_item(input logic kind, input logic [7:0] id,
                                         input logic [5:0] cnt, input logic [15:0] pos,
                                         input logic [15:0] tim, input logic [7:0] mode);
        scpf_in_t it;
        it.req_type    = kind;
        it.first_id    = id;
        it.servo_count = cnt;
        it.position    = pos;
        it.move_time   = tim;
        it.torque_mode = mode;
        return it;
    endfunction

    // one entry transfer; push stays high afterwards until the next call or a drain
    task automatic send_entry(input scpf_in_t it);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        push <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        frame_entry(it);
        entries_sent++;
    endtask

    // whole packet: first entry carries the header fields, the rest are random
    task automatic send_packet(input logic kind, input logic [7:0] id, input logic [5:0] cnt);
        scpf_in_t it;
        int       n;
        n = taken_count(cnt);
        it = random_item();
        it.req_type    = kind;
        it.first_id    = id;
        it.servo_count = cnt;
        send_entry(it);
        for (int i = 1; i < n; i++)
            send_entry(random_item());
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        // single move entry at the field extremes
        send_entry(mk_item(KIND_MOVE, 8'hFF, 6'd1, 16'h8000, 16'hFFFF, 8'hFF));
        // single torque entry, move fields all ones must be ignored
        send_entry(mk_item(KIND_TORQUE, 8'h00, 6'd1, 16'hFFFF, 16'hFFFF, 8'hFF));
        // two moves, id wraps from FF to 00; later entry header fields ignored
        send_entry(mk_item(KIND_MOVE, 8'hFF, 6'd2, 16'h7FFF, 16'h0000, 8'h00));
        send_entry(mk_item(KIND_TORQUE, 8'h12, 6'd63, 16'h0000, 16'h0001, 8'hAA));
        // zero count is taken as one
        send_entry(mk_item(KIND_TORQUE, 8'h80, 6'd0, 16'h1234, 16'h5678, 8'h00));
        send_entry(mk_item(KIND_MOVE, 8'h01, 6'd0, 16'h0000, 16'h0000, 8'h01));
        // three torque entries with mode on/off
        send_entry(mk_item(KIND_TORQUE, 8'hFE, 6'd3, 16'h0000, 16'h0000, 8'h01));
        send_entry(mk_item(KIND_MOVE, 8'h00, 6'd1, 16'hFFFF, 16'hFFFF, 8'h00));
        send_entry(mk_item(KIND_TORQUE, 8'hFF, 6'd0, 16'h0000, 16'h0000, 8'h01));
        // exactly the limit
        send_packet(KIND_MOVE, 8'h10, COUNT_MAX);
    endtask

    task automatic test_count_clamp();
        // count above the limit is taken as the limit
        send_packet(KIND_TORQUE, 8'hF0, 6'd63);
    endtask

    task automatic test_random_packets(input int n_entries);
        int       stop_at;
        logic [5:0] cnt;
        stop_at = entries_sent + n_entries;
        while (entries_sent < stop_at)
        begin
            cnt = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 4));
            send_packet(1'($urandom), 8'($urandom), cnt);
        end
    endtask

    task automatic test_backpressure();
        tx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 4; i++)
            send_packet(1'($urandom), 8'($urandom), 6'd3);
        tx_idle_on = 1'b1;
        // sender pause until everything is out
        wait_drained();
    endtask

    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_packets(10);
    endtask

    // receiver: pop with random stalls, check each byte transfer
    always @(posedge clk)
    begin : rx_side
        scpf_out_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $error("out_byte: expected nothing, got %02h (packet_end %0b)",
                           result.out_byte, result.packet_end);
                    fail_count++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, result.out_byte);
                        fail_count++;
                    end
                    if (result.packet_end !== want.packet_end)
                    begin
                        $error("packet_end: expected %0b, got %0b",
                               want.packet_end, result.packet_end);
                        fail_count++;
                    end
                end
            end
            if (rx_hold_req)
            begin
                rx_stall    = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            else if (rx_stall == 0 && rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                rx_stall = $urandom_range(1, 11);
            end
            if (rx_stall != 0)
            begin
                rx_stall--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_count_clamp();
        test_random_packets(8);
        test_backpressure();
        test_random_packets(4);
        test_steady_stream();

        wait_drained();
        if (fail_count == 0 && pending_bytes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/scpf_pkg.sv
rtl/core/scpf_front.sv
rtl/core/scpf_queue.sv
rtl/core/scpf_back.sv
rtl/core/servo_command_packet_framer.sv
tb/sv/servo_command_packet_framer_tb.sv
